// File: src/pbed_pkg.sv
// ----------------------------------------------------------------------------
// pbed_pkg
// Shared widths, constants and types of the point-to-box distance block.
// ----------------------------------------------------------------------------
package pbed_pkg;

   localparam int IN_W   = 24;          // signed Q12.12 coordinates
   localparam int GAP_W  = 24;          // gap magnitude, always below 2^24
   localparam int SQ_W   = 2 * GAP_W;   // exact Q24.24 square
   localparam int PAIR_W = SQ_W + 1;    // both squares of one element
   localparam int SUM_W  = 57;          // running sum, unsigned Q33.24
   localparam int DIST_W = 29;          // unsigned Q17.12 distance
   localparam int REM_W  = DIST_W + 1;  // partial remainder of the root
   localparam int ITER_W = 5;           // counts the root digits

   localparam logic [SUM_W-1:0]  SUM_CEIL  = {SUM_W{1'b1}};
   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(DIST_W - 1);

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             saturated;
   } sum_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } root_state_type;

endpackage

// File: src/point_box_euclidean_distance.sv
// ----------------------------------------------------------------------------
// point_box_euclidean_distance
// Streams vector elements, sums the squared gaps from a point to a box in
// signed Q12.12 and gives the floor square root of each vector's sum.
//
//   channel  prefix  direction  payload
//   input    req_    in         point_value, bound_low, bound_high, last_element
//   result   rsp_    out        distance_out, saturated
//
// The front end takes one element per cycle, while req_ready is high, through a
// three-stage subtract, square and accumulate pipe.
// Each vector end queues its sum; the root unit loads a sum, finds one result
// bit per run step and hands the result on before it takes the next sum.
// Reset is synchronous and clears the sum, the queue and all valid flags.
// req_ready falls only while a vector end waits for room in a full queue.
// ----------------------------------------------------------------------------
module point_box_euclidean_distance
   import pbed_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2    // at least 2
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [IN_W-1:0]  req_point_value,
   input  logic signed [IN_W-1:0]  req_bound_low,
   input  logic signed [IN_W-1:0]  req_bound_high,
   input  logic                    req_last_element,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [DIST_W-1:0]       rsp_distance_out,
   output logic                    rsp_saturated
);

   logic          push_valid;
   sum_entry_type push_entry;
   logic          queue_full;
   logic          queue_empty;
   sum_entry_type queue_head;
   logic          pop;

   pbed_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_point_value  (req_point_value),
      .req_bound_low    (req_bound_low),
      .req_bound_high   (req_bound_high),
      .req_last_element (req_last_element),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_entry       (push_entry)
   );

   pbed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (queue_head)
   );

   pbed_root u_root (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .queue_head       (queue_head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_distance_out (rsp_distance_out),
      .rsp_saturated    (rsp_saturated)
   );

endmodule

// File: src/pbed_front.sv
// ----------------------------------------------------------------------------
// pbed_front
// Takes one element a cycle unless stalled, forms the squared gaps to the box and
// keeps the saturating running sum; hands each vector's finished sum to the queue.
// ----------------------------------------------------------------------------
module pbed_front
   import pbed_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [IN_W-1:0]  req_point_value,
   input  logic signed [IN_W-1:0]  req_bound_low,
   input  logic signed [IN_W-1:0]  req_bound_high,
   input  logic                    req_last_element,
   input  logic                    queue_full,
   output logic                    push_valid,
   output sum_entry_type           push_entry
);

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_last_ff;
   logic [GAP_W-1:0]  s1_gap_lo_ff, s1_gap_lo_in;
   logic [GAP_W-1:0]  s1_gap_hi_ff, s1_gap_hi_in;
   logic              s2_valid_ff, s2_valid_in;
   logic              s2_last_ff;
   logic [SQ_W-1:0]   s2_sq_lo_ff;
   logic [SQ_W-1:0]   s2_sq_hi_ff;
   logic              s3_valid_ff, s3_valid_in;
   logic              s3_last_ff;
   logic [PAIR_W-1:0] s3_pair_ff;
   logic [SUM_W-1:0]  acc_sum_ff, acc_sum_in;
   logic              acc_sat_ff, acc_sat_in;

   logic                    stall;
   logic                    take;
   logic signed [IN_W:0]    diff_lo;
   logic signed [IN_W:0]    diff_hi;
   logic                    below;
   logic                    above;
   logic [SUM_W:0]          total;
   logic                    hit;
   logic [SUM_W-1:0]        step_sum;
   logic                    step_sat;

   // the whole pipe holds while a finished vector cannot enter the queue
   assign stall     = s3_valid_ff && s3_last_ff && queue_full;
   assign req_ready = !stall;
   assign take      = req_valid && !stall;

   always_comb begin
      diff_lo = {req_bound_low[IN_W-1], req_bound_low}
              - {req_point_value[IN_W-1], req_point_value};
      diff_hi = {req_point_value[IN_W-1], req_point_value}
              - {req_bound_high[IN_W-1], req_bound_high};
      below   = !diff_lo[IN_W] && (diff_lo != '0);
      above   = !diff_hi[IN_W] && (diff_hi != '0);
      s1_gap_lo_in = below ? diff_lo[GAP_W-1:0] : '0;
      s1_gap_hi_in = above ? diff_hi[GAP_W-1:0] : '0;
      s1_valid_in  = take;
      s2_valid_in  = s1_valid_ff;
      s3_valid_in  = s2_valid_ff;
   end

   always_comb begin
      total    = {1'b0, acc_sum_ff} + {{(SUM_W + 1 - PAIR_W){1'b0}}, s3_pair_ff};
      hit      = total[SUM_W];
      step_sum = hit ? SUM_CEIL : total[SUM_W-1:0];
      step_sat = acc_sat_ff || hit;
      acc_sum_in = acc_sum_ff;
      acc_sat_in = acc_sat_ff;
      if (s3_valid_ff && !stall) begin
         if (s3_last_ff) begin
            acc_sum_in = '0;
            acc_sat_in = 1'b0;
         end else begin
            acc_sum_in = step_sum;
            acc_sat_in = step_sat;
         end
      end
   end

   assign push_valid           = s3_valid_ff && s3_last_ff && !queue_full;
   assign push_entry.sum       = step_sum;
   assign push_entry.saturated = step_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         acc_sum_ff  <= '0;
         acc_sat_ff  <= 1'b0;
      end else begin
         if (!stall) begin
            s1_valid_ff <= s1_valid_in;
            s2_valid_ff <= s2_valid_in;
            s3_valid_ff <= s3_valid_in;
         end
         acc_sum_ff <= acc_sum_in;
         acc_sat_ff <= acc_sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_last_ff   <= req_last_element;
         s1_gap_lo_ff <= s1_gap_lo_in;
         s1_gap_hi_ff <= s1_gap_hi_in;
         s2_last_ff   <= s1_last_ff;
         s2_sq_lo_ff  <= s1_gap_lo_ff * s1_gap_lo_ff;
         s2_sq_hi_ff  <= s1_gap_hi_ff * s1_gap_hi_ff;
         s3_last_ff   <= s2_last_ff;
         s3_pair_ff   <= {1'b0, s2_sq_lo_ff} + {1'b0, s2_sq_hi_ff};
      end
   end

`ifndef SYNTH
   // a sticky saturation flag always sits with the sum pinned at its ceiling
   a_sat_at_ceiling: assert property (@(posedge clock) disable iff (reset)
      acc_sat_ff |-> (acc_sum_ff == SUM_CEIL))
      else $error("saturation flag set with sum below ceiling");

   // the sum starts from zero after every finished vector
   a_clear_after_push: assert property (@(posedge clock) disable iff (reset)
      push_valid |=> (acc_sum_ff == '0) && !acc_sat_ff)
      else $error("running sum not cleared after vector end");

   // a held vector end keeps the pipe frozen
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> s3_valid_ff && s3_last_ff)
      else $error("stalled vector end lost");
`endif

endmodule

// File: src/pbed_queue.sv
// ----------------------------------------------------------------------------
// pbed_queue
// Short first-in first-out store of finished sums between the accumulator
// and the square root unit.
// ----------------------------------------------------------------------------
module pbed_queue
   import pbed_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  sum_entry_type push_entry,
   input  logic          pop,
   output logic          full,
   output logic          empty,
   output sum_entry_type head
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastSlot = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt  = CntW'(DEPTH);

   sum_entry_type       slot_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == FullCnt);
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("queue fill beyond its depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from an empty queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push_valid)
      else $error("push into a full queue");
`endif

endmodule

// File: src/pbed_root.sv
// ----------------------------------------------------------------------------
// pbed_root
// Digit-by-digit floor square root of a queued sum, one result bit a cycle,
// with the result held in an output register.
// ----------------------------------------------------------------------------
module pbed_root
   import pbed_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   input  sum_entry_type     queue_head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DIST_W-1:0] rsp_distance_out,
   output logic              rsp_saturated
);

   localparam int RadW = 2 * DIST_W;

   root_state_type      state_ff, state_in;
   logic [RadW-1:0]     rad_ff, rad_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [DIST_W-1:0]   root_ff, root_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;
   logic                sat_ff, sat_in;
   logic                out_valid_ff, out_valid_in;
   logic [DIST_W-1:0]   out_dist_ff;
   logic                out_sat_ff;

   logic [REM_W+1:0]    rem_shift;
   logic [REM_W+1:0]    trial;
   logic                fits;
   logic                load_out;

   // bring down the next pair of radicand bits and try root*4+1
   assign rem_shift = {rem_ff, rad_ff[RadW-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign fits      = (rem_shift >= trial);

   assign pop      = (state_ff == ST_IDLE) && !queue_empty;
   assign load_out = (state_ff == ST_DONE) && (!out_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      iter_in      = iter_ff;
      sat_in       = sat_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               rad_in   = {{(RadW - SUM_W){1'b0}}, queue_head.sum};
               sat_in   = queue_head.saturated;
               rem_in   = '0;
               root_in  = '0;
               iter_in  = LAST_ITER;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            rad_in = {rad_ff[RadW-3:0], 2'b00};
            if (fits) begin
               rem_in  = REM_W'(rem_shift - trial);
               root_in = {root_ff[DIST_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift[REM_W-1:0];
               root_in = {root_ff[DIST_W-2:0], 1'b0};
            end
            iter_in = iter_ff - 1'b1;
            if (iter_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      iter_ff <= iter_in;
      sat_ff  <= sat_in;
      if (load_out) begin
         out_dist_ff <= root_ff;
         out_sat_ff  <= sat_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_distance_out = out_dist_ff;
   assign rsp_saturated    = out_sat_ff;

`ifndef SYNTH
   // a new result only ever comes out of the finished state
   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised without a finished root");

   // the digit loop leaves after its final step
   a_run_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && (iter_ff == '0) |=> (state_ff == ST_DONE))
      else $error("root loop overran its digit count");

   // the partial remainder never exceeds twice the partial root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (rem_ff <= {root_ff, 1'b0}))
      else $error("root remainder out of range");
`endif

endmodule
